// ===== hdl/ssca_pkg.sv =====
`default_nettype none
package ssca_pkg;

    localparam int MAX_CLASSES  = 64;
    localparam int HEADER_BYTES = 48;
    localparam int ARENA_BYTES  = 1048576;
    localparam int ALIGN_BYTES  = 8;
    localparam int NSLOTS       = ARENA_BYTES / ALIGN_BYTES;
    localparam int CLS_AW       = $clog2(MAX_CLASSES);
    localparam int SLOT_W       = $clog2(NSLOTS);

    localparam logic [19:0] DEFAULT_FACTOR = 20'd78643;
    localparam logic [19:0] UNITY_FACTOR   = 20'd65536;
    localparam logic [17:0] COUNT_MAX      = 18'h3FFFF;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STS_NO_MEM    = 2'd2;
    localparam logic [1:0] STS_PREFILL   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_DATA = 3'd0;
    localparam logic [2:0] REG_MAX_DATA = 3'd1;
    localparam logic [2:0] REG_BATCH    = 3'd2;
    localparam logic [2:0] REG_GROWTH   = 3'd3;
    localparam logic [2:0] REG_ARENA    = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] req_bytes;
        logic [5:0]  free_class;
        logic [19:0] item_address;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] address;
        logic [5:0]  class_index;
        logic [20:0] data_capacity;
        logic [6:0]  class_count;
    } t_res;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic [17:0]       cnt;
    } t_list;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_CHK,
        S_BLD_MUL,
        S_BLD_TAIL,
        S_PF_NEXT,
        S_PF_SZ,
        S_LK_RD,
        S_LK_CMP,
        S_LS_RD,
        S_LS_LAT,
        S_CV_CHK,
        S_CV_PUSH,
        S_POP,
        S_POP_LAT,
        S_FREE_PUSH,
        S_DONE
    } t_state;

    // round up to the alignment, zero becomes one alignment unit
    function automatic logic [24:0] align_up(input logic [24:0] x);
        logic [24:0] a;
        a = (x + 25'(ALIGN_BYTES - 1)) & ~25'(ALIGN_BYTES - 1);
        return (a == 25'd0) ? 25'(ALIGN_BYTES) : a;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ssca_ram.sv =====
`default_nettype none
module ssca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/slab_size_class_allocator_unit.sv =====
`default_nettype none
// Slab size-class allocator over a byte arena. Pulse i_start with a command
// while o_busy is low; the block answers every command with exactly one
// result, shown on o_res for one cycle with o_done high. The receiver cannot
// stall it, so capture o_res whenever o_done is high. One command is worked
// at a time on a shared datapath (one 20x20 multiplier, single-port reads of
// the class, list and link memories):
//   init    : builds the class table, then carves one batch per class
//             from the arena to prefill its list;
//   allocate: scans the classes first-fit and pops the chosen list, first
//             refilling it from the arena when it is empty;
//   free    : pushes the item to its list's tail; other commands only answer.
// The carve loop, one item per cycle, dominates init and refills.
// Configuration writes on i_cfg_* take effect at once; write them only while
// the block is idle. Registers are sampled at init, except the arena limit.
module slab_size_class_allocator_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire ssca_pkg::t_cmd      i_cmd,
    output logic                     o_busy,
    output logic                     o_done,
    output ssca_pkg::t_res           o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [20:0]         i_cfg_data
);

    localparam int CAW = ssca_pkg::CLS_AW;
    localparam int SW  = ssca_pkg::SLOT_W;

    // configuration registers
    logic [15:0] r_cfg_min;
    logic [19:0] r_cfg_max;
    logic [20:0] r_cfg_batch;
    logic [19:0] r_cfg_gf;
    logic [20:0] r_cfg_lim;

    // control state
    ssca_pkg::t_state r_state, n_state;
    logic [6:0]       r_built, n_built;
    logic [20:0]      r_top, n_top;
    logic [20:0]      r_batch, n_batch;
    logic [ssca_pkg::MAX_CLASSES-1:0] r_lst_vld, n_lst_vld;

    // working registers
    logic [1:0]    r_op, n_op;
    logic [21:0]   r_want, n_want;
    logic [19:0]   r_free_addr, n_free_addr;
    logic [19:0]   r_f, n_f;
    logic [19:0]   r_hi, n_hi;
    logic [24:0]   r_s, n_s;
    logic [19:0]   r_last, n_last;
    logic [39:0]   r_prod, n_prod;
    logic [6:0]    r_idx, n_idx;
    logic [CAW-1:0] r_cls, n_cls;
    logic [20:0]   r_size, n_size;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [17:0]   r_cnt, n_cnt;
    logic [21:0]   r_off, n_off;
    logic          r_vld_rd, n_vld_rd;

    // result registers
    logic [1:0]     r_status, n_status;
    logic [19:0]    r_addr, n_addr;
    logic [CAW-1:0] r_res_cls, n_res_cls;
    logic [20:0]    r_cap, n_cap;

    // memory ports
    logic           cs_we;
    logic [CAW-1:0] cs_waddr, cs_raddr;
    logic [20:0]    cs_wdata, cs_rdata;
    logic           ls_we;
    logic [CAW-1:0] ls_waddr;
    ssca_pkg::t_list ls_wdata, ls_rdata, ls_cur;
    logic           ns_we;
    logic [SW-1:0]  ns_waddr, ns_wdata, ns_raddr, ns_rdata;

    // datapath helpers
    logic [20:0] lim;
    logic [20:0] push_sum;
    logic [SW-1:0] push_slot;
    logic [SW-1:0] free_slot;
    logic [17:0]   cnt_inc;

    ssca_ram #(.WIDTH(21), .DEPTH(ssca_pkg::MAX_CLASSES)) u_cls_ram (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_raddr (cs_raddr),
        .o_rdata (cs_rdata)
    );

    ssca_ram #(.WIDTH($bits(ssca_pkg::t_list)), .DEPTH(ssca_pkg::MAX_CLASSES)) u_lst_ram (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (ls_wdata),
        .i_raddr (r_cls),
        .o_rdata (ls_rdata)
    );

    ssca_ram #(.WIDTH(SW), .DEPTH(ssca_pkg::NSLOTS)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (ns_we),
        .i_waddr (ns_waddr),
        .i_wdata (ns_wdata),
        .i_raddr (ns_raddr),
        .o_rdata (ns_rdata)
    );

    // a list entry not written since init reads as empty
    assign ls_cur    = r_vld_rd ? ls_rdata : '0;
    assign lim       = (r_cfg_lim < 21'(ssca_pkg::ARENA_BYTES)) ? r_cfg_lim
                                                               : 21'(ssca_pkg::ARENA_BYTES);
    assign push_sum  = r_top + r_off[20:0];
    assign push_slot = push_sum[19:3];
    assign free_slot = r_free_addr[19:3];
    assign cnt_inc   = (r_cnt < ssca_pkg::COUNT_MAX) ? r_cnt + 18'd1 : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_top       = r_top;
        n_batch     = r_batch;
        n_lst_vld   = r_lst_vld;
        n_op        = r_op;
        n_want      = r_want;
        n_free_addr = r_free_addr;
        n_f         = r_f;
        n_hi        = r_hi;
        n_s         = r_s;
        n_last      = r_last;
        n_prod      = r_prod;
        n_idx       = r_idx;
        n_cls       = r_cls;
        n_size      = r_size;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_off       = r_off;
        n_vld_rd    = r_vld_rd;
        n_status    = r_status;
        n_addr      = r_addr;
        n_res_cls   = r_res_cls;
        n_cap       = r_cap;
        cs_we       = 1'b0;
        cs_waddr    = r_built[CAW-1:0];
        cs_wdata    = {1'b0, r_s[19:0]};
        cs_raddr    = r_idx[CAW-1:0];
        ls_we       = 1'b0;
        ls_waddr    = r_cls;
        ls_wdata    = '{head: r_head, tail: r_tail, cnt: r_cnt};
        ns_we       = 1'b0;
        ns_waddr    = r_tail;
        ns_wdata    = push_slot;
        ns_raddr    = r_head;
        o_done      = 1'b0;

        case (r_state)
            ssca_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op        = i_cmd.op;
                    n_want      = {1'b0, i_cmd.req_bytes} + 22'(ssca_pkg::HEADER_BYTES);
                    n_free_addr = i_cmd.item_address;
                    n_status    = ssca_pkg::STS_OK;
                    n_addr      = '0;
                    n_res_cls   = '0;
                    n_cap       = '0;
                    n_idx       = '0;
                    case (i_cmd.op)
                        ssca_pkg::OP_INIT: begin
                            n_f = (r_cfg_gf <= ssca_pkg::UNITY_FACTOR)
                                ? ssca_pkg::DEFAULT_FACTOR : r_cfg_gf;
                            n_s = ssca_pkg::align_up(25'(r_cfg_min)
                                + 25'(ssca_pkg::HEADER_BYTES));
                            n_hi = 20'(ssca_pkg::align_up(25'(r_cfg_max)
                                + 25'(ssca_pkg::HEADER_BYTES)));
                            n_built   = '0;
                            n_top     = '0;
                            n_lst_vld = '0;
                            n_state   = ssca_pkg::S_BLD_CHK;
                        end
                        ssca_pkg::OP_ALLOC: begin
                            n_state = ssca_pkg::S_LK_RD;
                        end
                        ssca_pkg::OP_FREE: begin
                            n_cls   = i_cmd.free_class;
                            n_state = ({1'b0, i_cmd.free_class} < r_built)
                                ? ssca_pkg::S_LS_RD : ssca_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ssca_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // geometric table: write, multiply, truncate and align
            ssca_pkg::S_BLD_CHK: begin
                if (r_s <= {5'd0, r_hi} && r_built < 7'(ssca_pkg::MAX_CLASSES - 1)) begin
                    cs_we   = 1'b1;
                    n_last  = r_s[19:0];
                    n_built = r_built + 7'd1;
                    n_prod  = r_s[19:0] * r_f;
                    n_state = ssca_pkg::S_BLD_MUL;
                end else begin
                    n_state = ssca_pkg::S_BLD_TAIL;
                end
            end

            ssca_pkg::S_BLD_MUL: begin
                n_s     = ssca_pkg::align_up({1'b0, r_prod[39:16]});
                n_state = ssca_pkg::S_BLD_CHK;
            end

            // append the maximum class, fix the batch size
            ssca_pkg::S_BLD_TAIL: begin
                if (r_built == 7'd0 || r_last < r_hi) begin
                    cs_we    = 1'b1;
                    cs_wdata = {1'b0, r_hi};
                    n_built  = r_built + 7'd1;
                end
                n_batch = (r_cfg_batch < {1'b0, r_hi}) ? {1'b0, r_hi} : r_cfg_batch;
                n_idx   = '0;
                n_state = ssca_pkg::S_PF_NEXT;
            end

            ssca_pkg::S_PF_NEXT: begin
                if (r_idx < r_built) begin
                    n_cls   = r_idx[CAW-1:0];
                    n_state = ssca_pkg::S_PF_SZ;
                end else begin
                    n_state = ssca_pkg::S_DONE;
                end
            end

            // lists were emptied at init
            ssca_pkg::S_PF_SZ: begin
                n_size  = cs_rdata;
                n_head  = '0;
                n_tail  = '0;
                n_cnt   = '0;
                n_state = ssca_pkg::S_CV_CHK;
            end

            // first-fit scan over the built classes
            ssca_pkg::S_LK_RD: begin
                if (r_idx < r_built) begin
                    n_state = ssca_pkg::S_LK_CMP;
                end else begin
                    n_status = ssca_pkg::STS_TOO_LARGE;
                    n_state  = ssca_pkg::S_DONE;
                end
            end

            ssca_pkg::S_LK_CMP: begin
                if ({1'b0, cs_rdata} >= r_want) begin
                    n_cls     = r_idx[CAW-1:0];
                    n_res_cls = r_idx[CAW-1:0];
                    n_size    = cs_rdata;
                    n_cap     = cs_rdata - 21'(ssca_pkg::HEADER_BYTES);
                    n_state   = ssca_pkg::S_LS_RD;
                end else begin
                    n_idx   = r_idx + 7'd1;
                    n_state = ssca_pkg::S_LK_RD;
                end
            end

            ssca_pkg::S_LS_RD: begin
                n_vld_rd = r_lst_vld[r_cls];
                n_state  = ssca_pkg::S_LS_LAT;
            end

            ssca_pkg::S_LS_LAT: begin
                n_head = ls_cur.head;
                n_tail = ls_cur.tail;
                n_cnt  = ls_cur.cnt;
                if (r_op == ssca_pkg::OP_FREE) begin
                    n_state = ssca_pkg::S_FREE_PUSH;
                end else if (ls_cur.cnt == 18'd0) begin
                    n_state = ssca_pkg::S_CV_CHK;
                end else begin
                    n_state = ssca_pkg::S_POP;
                end
            end

            // carve one batch from the arena top
            ssca_pkg::S_CV_CHK: begin
                n_off = '0;
                if ({1'b0, r_top} + {1'b0, r_batch} > {1'b0, lim}) begin
                    n_status = (r_op == ssca_pkg::OP_INIT)
                        ? ssca_pkg::STS_PREFILL : ssca_pkg::STS_NO_MEM;
                    n_state  = ssca_pkg::S_DONE;
                end else begin
                    n_state = ssca_pkg::S_CV_PUSH;
                end
            end

            ssca_pkg::S_CV_PUSH: begin
                if (r_off + {1'b0, r_size} <= {1'b0, r_batch}) begin
                    ns_we  = (r_cnt != 18'd0);
                    n_head = (r_cnt == 18'd0) ? push_slot : r_head;
                    n_tail = push_slot;
                    n_cnt  = cnt_inc;
                    n_off  = r_off + {1'b0, r_size};
                end else begin
                    n_top            = r_top + r_batch;
                    ls_we            = 1'b1;
                    n_lst_vld[r_cls] = 1'b1;
                    if (r_op == ssca_pkg::OP_INIT) begin
                        n_idx   = r_idx + 7'd1;
                        n_state = ssca_pkg::S_PF_NEXT;
                    end else begin
                        n_state = ssca_pkg::S_POP;
                    end
                end
            end

            // pop the head; fetch its link when more remain
            ssca_pkg::S_POP: begin
                if (r_cnt == 18'd0) begin
                    n_status = ssca_pkg::STS_NO_MEM;
                    n_state  = ssca_pkg::S_DONE;
                end else begin
                    n_addr = {r_head, 3'd0};
                    if (r_cnt > 18'd1) begin
                        n_state = ssca_pkg::S_POP_LAT;
                    end else begin
                        ls_we            = 1'b1;
                        ls_wdata.cnt     = r_cnt - 18'd1;
                        n_lst_vld[r_cls] = 1'b1;
                        n_state          = ssca_pkg::S_DONE;
                    end
                end
            end

            ssca_pkg::S_POP_LAT: begin
                ls_we            = 1'b1;
                ls_wdata.head    = ns_rdata;
                ls_wdata.cnt     = r_cnt - 18'd1;
                n_lst_vld[r_cls] = 1'b1;
                n_state          = ssca_pkg::S_DONE;
            end

            // push to the tail
            ssca_pkg::S_FREE_PUSH: begin
                ns_we            = (r_cnt != 18'd0);
                ns_wdata         = free_slot;
                ls_we            = 1'b1;
                ls_wdata.head    = (r_cnt == 18'd0) ? free_slot : r_head;
                ls_wdata.tail    = free_slot;
                ls_wdata.cnt     = cnt_inc;
                n_lst_vld[r_cls] = 1'b1;
                n_state          = ssca_pkg::S_DONE;
            end

            ssca_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = ssca_pkg::S_IDLE;
            end

            default: begin
                n_state = ssca_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ssca_pkg::S_IDLE);

    assign o_res = '{
        status:        r_status,
        address:       r_addr,
        class_index:   r_res_cls,
        data_capacity: r_cap,
        class_count:   r_built
    };

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min   <= 16'd48;
            r_cfg_max   <= 20'd8192;
            r_cfg_batch <= 21'd65536;
            r_cfg_gf    <= 20'd78643;
            r_cfg_lim   <= 21'd1048576;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssca_pkg::REG_MIN_DATA: r_cfg_min   <= i_cfg_data[15:0];
                ssca_pkg::REG_MAX_DATA: r_cfg_max   <= i_cfg_data[19:0];
                ssca_pkg::REG_BATCH:    r_cfg_batch <= i_cfg_data;
                ssca_pkg::REG_GROWTH:   r_cfg_gf    <= i_cfg_data[19:0];
                ssca_pkg::REG_ARENA:    r_cfg_lim   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssca_pkg::S_IDLE;
            r_built   <= '0;
            r_top     <= '0;
            r_batch   <= '0;
            r_lst_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_built   <= n_built;
            r_top     <= n_top;
            r_batch   <= n_batch;
            r_lst_vld <= n_lst_vld;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_want      <= n_want;
        r_free_addr <= n_free_addr;
        r_f         <= n_f;
        r_hi        <= n_hi;
        r_s         <= n_s;
        r_last      <= n_last;
        r_prod      <= n_prod;
        r_idx       <= n_idx;
        r_cls       <= n_cls;
        r_size      <= n_size;
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_cnt       <= n_cnt;
        r_off       <= n_off;
        r_vld_rd    <= n_vld_rd;
        r_status    <= n_status;
        r_addr      <= n_addr;
        r_res_cls   <= n_res_cls;
        r_cap       <= n_cap;
    end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ssca_pkg::*;

    // Cycles without any accepted item or any result before the run is abandoned.
    // One init can carve up to ARENA_BYTES / 48 items at one item per cycle.
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SHOW_MAX       = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_cmd        i_cmd;
    logic        o_busy;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [20:0] i_cfg_data;

    slab_size_class_allocator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator shadow: registers, class table, free lists, arena.
    // ------------------------------------------------------------------
    logic [15:0] cfg_min_data;
    logic [19:0] cfg_max_data;
    logic [20:0] cfg_batch;
    logic [19:0] cfg_growth;
    logic [20:0] cfg_arena;

    logic [20:0] class_bytes [MAX_CLASSES];
    logic [16:0] fl_head     [MAX_CLASSES];
    logic [16:0] fl_tail     [MAX_CLASSES];
    logic [17:0] fl_count    [MAX_CLASSES];
    logic [16:0] slot_link   [NSLOTS];
    logic [20:0] arena_top;
    logic [6:0]  n_classes;
    logic [20:0] refill_bytes;

    typedef struct {
        logic [5:0]  cls;
        logic [19:0] addr;
    } t_live;

    t_res  expected_results [$];
    t_live live_items [$];
    int    mismatches;
    int    unexpected;
    int    idle_cycles;
    bit    no_gaps;

    function automatic longint unsigned round8(longint unsigned x);
        longint unsigned a;
        a = ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        return (a == 0) ? ALIGN_BYTES : a;
    endfunction

    function automatic void push_free(int c, longint unsigned addr);
        logic [16:0] slot;
        if (addr / ALIGN_BYTES >= NSLOTS) return;
        slot = 17'(addr / ALIGN_BYTES);
        if (fl_count[c] == 0) fl_head[c] = slot;
        else slot_link[fl_tail[c]] = slot;
        fl_tail[c] = slot;
        if (fl_count[c] < COUNT_MAX) fl_count[c] = fl_count[c] + 1;
    endfunction

    function automatic bit carve_batch(int c);
        longint unsigned lim;
        longint unsigned off;
        lim = (cfg_arena < ARENA_BYTES) ? cfg_arena : ARENA_BYTES;
        if (longint'(arena_top) + refill_bytes > lim) return 1'b0;
        for (off = 0; off + class_bytes[c] <= refill_bytes; off += class_bytes[c])
            push_free(c, arena_top + off);
        arena_top = 21'(arena_top + refill_bytes);
        return 1'b1;
    endfunction

    function automatic logic [1:0] build_table();
        longint unsigned f;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned s;
        int n;
        f  = (cfg_growth <= UNITY_FACTOR) ? DEFAULT_FACTOR : cfg_growth;
        lo = round8(cfg_min_data + HEADER_BYTES);
        hi = round8(cfg_max_data + HEADER_BYTES);
        s  = lo;
        n  = 0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            fl_head[c] = '0;
            fl_tail[c] = '0;
            fl_count[c] = '0;
        end
        arena_top = '0;
        while (s <= hi && n < MAX_CLASSES - 1) begin
            class_bytes[n] = 21'(s);
            n++;
            s = round8((s * f) >> 16);
        end
        if (n == 0 || class_bytes[n-1] < hi) begin
            class_bytes[n] = 21'(hi);
            n++;
        end
        n_classes = 7'(n);
        refill_bytes = (cfg_batch < hi) ? 21'(hi) : cfg_batch;
        for (int c = 0; c < n; c++)
            if (!carve_batch(c)) return STS_PREFILL;
        return STS_OK;
    endfunction

    function automatic t_res predict_result(t_cmd c);
        t_res r;
        longint unsigned want;
        int k;
        bit hit;
        r = '0;
        case (c.op)
            OP_INIT: r.status = build_table();
            OP_ALLOC: begin
                want = c.req_bytes + HEADER_BYTES;
                hit = 1'b0;
                for (k = 0; k < n_classes; k++)
                    if (class_bytes[k] >= want) begin
                        hit = 1'b1;
                        break;
                    end
                if (!hit) begin
                    r.status = STS_TOO_LARGE;
                end else begin
                    r.class_index = 6'(k);
                    r.data_capacity = 21'(class_bytes[k] - HEADER_BYTES);
                    if (fl_count[k] == 0 && !carve_batch(k)) r.status = STS_NO_MEM;
                    else if (fl_count[k] == 0) r.status = STS_NO_MEM;
                    else begin
                        r.address = {fl_head[k], 3'b000};
                        if (fl_count[k] > 1) fl_head[k] = slot_link[fl_head[k]];
                        fl_count[k] = fl_count[k] - 1;
                    end
                end
            end
            OP_FREE: if (c.free_class < n_classes) push_free(c.free_class, c.item_address);
            default: ;
        endcase
        r.class_count = n_classes;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobed result pairs with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= SHOW_MAX)
                    $display("unexpected result %p", o_res);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_res.status !== exp_r.status || o_res.address !== exp_r.address ||
                    o_res.class_index !== exp_r.class_index ||
                    o_res.data_capacity !== exp_r.data_capacity ||
                    o_res.class_count !== exp_r.class_count) begin
                    mismatches++;
                    if (mismatches + unexpected <= SHOW_MAX)
                        $display("mismatch: expected %p, actual %p", exp_r, o_res);
                end
            end
        end
    end

    // Watchdog: count cycles in which no item is taken and no result shows.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Present one item, hold it until taken, then maybe leave a short gap.
    task automatic send_item(t_cmd c);
        t_res r;
        t_live li;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        r = predict_result(c);
        expected_results = {expected_results, r};
        if (c.op == OP_INIT) live_items.delete();
        if (c.op == OP_ALLOC && r.status == STS_OK) begin
            li.cls = r.class_index;
            li.addr = r.address;
            live_items = {live_items, li};
        end
        if (!no_gaps && $urandom_range(99) < 13) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Drop start and hold off until every pending result has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [20:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_MIN_DATA: cfg_min_data = value[15:0];
            REG_MAX_DATA: cfg_max_data = value[19:0];
            REG_BATCH:    cfg_batch    = value;
            REG_GROWTH:   cfg_growth   = value[19:0];
            REG_ARENA:    cfg_arena    = value;
            default: ;
        endcase
    endtask

    task automatic setup(int mn, int mx, int bt, int gf, int ar);
        drain();
        write_reg(REG_MIN_DATA, 21'(mn));
        write_reg(REG_MAX_DATA, 21'(mx));
        write_reg(REG_BATCH, 21'(bt));
        write_reg(REG_GROWTH, 21'(gf));
        write_reg(REG_ARENA, 21'(ar));
    endtask

    task automatic do_op(logic [1:0] op, int ds, int fc, int fa);
        t_cmd c;
        c.op = op;
        c.req_bytes = 21'(ds);
        c.free_class = 6'(fc);
        c.item_address = 20'(fa);
        send_item(c);
    endtask

    // Release an outstanding item, or any class and address now and then.
    task automatic free_something();
        t_live li;
        int k;
        if (live_items.size() == 0 || $urandom_range(99) < 10) begin
            do_op(OP_FREE, $urandom, $urandom_range(63), $urandom_range(20'hFFFFF));
        end else begin
            k = $urandom_range(live_items.size() - 1);
            li = live_items[k];
            live_items.delete(k);
            do_op(OP_FREE, $urandom, li.cls, li.addr);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_before_init();
        do_op(OP_ALLOC, 0, 0, 0);
        do_op(OP_FREE, 0, 0, 0);
        do_op(OP_NOP, 21'h1FFFFF, 63, 20'hFFFFF);
    endtask

    task automatic test_default_table();
        setup(48, 8192, 65536, 78643, 1048576);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        do_op(OP_ALLOC, 8192, 0, 0);
        do_op(OP_ALLOC, 8193, 0, 0);
        do_op(OP_ALLOC, 21'h1FFFFF, 0, 0);
        do_op(OP_FREE, 0, 63, 0);
        free_something();
        do_op(OP_ALLOC, 0, 0, 0);
    endtask

    task automatic test_table_shapes();
        // minimum above maximum leaves a single class
        setup(65535, 0, 0, 65536, 1048576);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        // barely growing factor repeats entries up to the bound
        setup(0, 2000, 4096, 65537, 1048576);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 1000, 0, 0);
        // steepest factor, largest payload
        setup(0, 524288, 1048576, 1048575, 2097151);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 524288, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
    endtask

    task automatic test_arena_limits();
        // empty arena: prefill fails, allocate runs out of memory
        setup(0, 0, 0, 0, 0);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        // room for two single-item batches
        drain();
        write_reg(REG_ARENA, 21'd100);
        do_op(OP_INIT, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        do_op(OP_ALLOC, 0, 0, 0);
        // init again resets the arena
        do_op(OP_INIT, 0, 0, 0);
    endtask

    task automatic test_random(int n_phases, int per_phase);
        int mn, mx, bt, gf, ar, pick;
        for (int p = 0; p < n_phases; p++) begin
            pick = $urandom_range(3);
            mn = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(65535) : $urandom_range(400);
            pick = $urandom_range(4);
            mx = (pick == 0) ? 524288 : (pick == 1) ? 0 : $urandom_range(16384);
            pick = $urandom_range(3);
            bt = (pick == 0) ? 0 : (pick == 1) ? 1048576 : $urandom_range(131072);
            pick = $urandom_range(3);
            gf = (pick == 0) ? $urandom_range(20'hFFFFF) : (pick == 1) ? 65537 :
                 $urandom_range(70000, 200000);
            pick = $urandom_range(3);
            ar = (pick == 0) ? 2097151 : (pick == 1) ? $urandom_range(1048576) :
                 $urandom_range(300000);
            setup(mn, mx, bt, gf, ar);
            no_gaps = (p == n_phases / 2);
            do_op(OP_INIT, 0, 0, 0);
            for (int i = 0; i < per_phase; i++) begin
                pick = $urandom_range(99);
                if (i == per_phase / 2 && p == 1) drain();
                if (pick < 55) begin
                    if ($urandom_range(4) == 0)
                        do_op(OP_ALLOC, $urandom & 21'h1FFFFF, 0, 0);
                    else
                        do_op(OP_ALLOC, $urandom_range(cfg_max_data + 64), 0, 0);
                end else if (pick < 94) free_something();
                else if (pick < 98) do_op(OP_NOP, $urandom, $urandom, $urandom);
                else do_op(OP_INIT, 0, 0, 0);
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_cmd      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches = 0;
        unexpected = 0;
        no_gaps    = 1'b0;
        cfg_min_data = 16'd48;
        cfg_max_data = 20'd8192;
        cfg_batch    = 21'd65536;
        cfg_growth   = DEFAULT_FACTOR;
        cfg_arena    = 21'd1048576;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            class_bytes[c] = '0;
            fl_head[c] = '0;
            fl_tail[c] = '0;
            fl_count[c] = '0;
        end
        arena_top = '0;
        n_classes = '0;
        refill_bytes = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_before_init();
        test_default_table();
        test_table_shapes();
        test_arena_limits();
        test_random(10, 108);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/ssca_pkg.sv
hdl/ssca_ram.sv
hdl/slab_size_class_allocator_unit.sv
bench/tb.sv
